/* rtl/core/escaped_frame_deframer_crc16_unit_defines.svh */
// Assertion macros used by the deframer receiver RTL (dfrm_rx).
`ifndef ESCAPED_FRAME_DEFRAMER_CRC16_UNIT_DEFINES_SVH
`define ESCAPED_FRAME_DEFRAMER_CRC16_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define DFRM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define DFRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dfrm_pkg.sv */
// Shared types, constants and the CRC step function of the frame deframer.
package dfrm_pkg;

  // Default maximum payload length of one frame.
  localparam int MAX_PAYLOAD_DEF = 32;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // CRC-16/XMODEM polynomial and the top bit that drives the feedback.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Register reset values.
  localparam logic [15:0] IDLE_LIMIT_RST   = 16'd0;
  localparam logic [7:0]  START_VALUE_RST  = 8'd126;
  localparam logic [7:0]  ESCAPE_VALUE_RST = 8'd94;
  localparam logic [7:0]  ESCAPE_MASK_RST  = 8'd32;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_IDLE_LIMIT   = 2'd0,
    REG_START_VALUE  = 2'd1,
    REG_ESCAPE_VALUE = 2'd2,
    REG_ESCAPE_MASK  = 2'd3
  } reg_idx_t;

  // Input commands.
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } command_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_GOOD    = 3'd2,
    ST_RESYNC  = 3'd3,
    ST_BADLEN  = 3'd4,
    ST_BADCRC  = 3'd5,
    ST_TIMEOUT = 3'd6
  } status_t;

  // Receiver phase.
  typedef enum logic [1:0] {
    PH_WAIT_START = 2'd0,
    PH_WAIT_LEN   = 2'd1,
    PH_READ_ENC   = 2'd2
  } phase_t;

  // Payload emission sequencer.
  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_RD   = 2'd1,
    SEQ_OUT  = 2'd2
  } seq_t;

  // One input item.
  typedef struct packed {
    command_t   command;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    status_t    status;
    logic [7:0] payload_byte;
    logic [7:0] frame_bytes;
    logic       last;
  } out_item_t;

  // Configuration register values handed to the receiver.
  typedef struct packed {
    logic [15:0] idle_limit;
    logic [7:0]  start_value;
    logic [7:0]  escape_value;
    logic [7:0]  escape_mask;
  } cfg_regs_t;

  // One byte of CRC-16/XMODEM, MSB first, no reflection.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/dfrm_regs.sv */
// Configuration register file behind the APB-style port.
module dfrm_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [dfrm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [dfrm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [dfrm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output dfrm_pkg::cfg_regs_t              regs
);

  dfrm_pkg::cfg_regs_t   regs_r;
  dfrm_pkg::cfg_regs_t   regs_nxt;
  dfrm_pkg::reg_idx_t    idx;
  logic                  wr_en;

  assign idx   = dfrm_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  // Register update on the access cycle of a write transfer.
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (idx)
        dfrm_pkg::REG_IDLE_LIMIT:   regs_nxt.idle_limit   = cfg_pwdata[15:0];
        dfrm_pkg::REG_START_VALUE:  regs_nxt.start_value  = cfg_pwdata[7:0];
        dfrm_pkg::REG_ESCAPE_VALUE: regs_nxt.escape_value = cfg_pwdata[7:0];
        dfrm_pkg::REG_ESCAPE_MASK:  regs_nxt.escape_mask  = cfg_pwdata[7:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.idle_limit   <= dfrm_pkg::IDLE_LIMIT_RST;
      regs_r.start_value  <= dfrm_pkg::START_VALUE_RST;
      regs_r.escape_value <= dfrm_pkg::ESCAPE_VALUE_RST;
      regs_r.escape_mask  <= dfrm_pkg::ESCAPE_MASK_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // Read-back mux.
  always_comb begin
    case (idx)
      dfrm_pkg::REG_IDLE_LIMIT:   cfg_prdata = {16'h0000, regs_r.idle_limit};
      dfrm_pkg::REG_START_VALUE:  cfg_prdata = {24'h000000, regs_r.start_value};
      dfrm_pkg::REG_ESCAPE_VALUE: cfg_prdata = {24'h000000, regs_r.escape_value};
      dfrm_pkg::REG_ESCAPE_MASK:  cfg_prdata = {24'h000000, regs_r.escape_mask};
      default:                    cfg_prdata = '0;
    endcase
  end

  assign regs = regs_r;

endmodule

/* rtl/core/dfrm_store.sv */
// Payload byte memory: one write port, one registered read port.
module dfrm_store #(
  parameter int DEPTH  = dfrm_pkg::MAX_PAYLOAD_DEF,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/dfrm_rx.sv */
// Frame decoder, CRC check and payload emission sequencer.
`include "escaped_frame_deframer_crc16_unit_defines.svh"

module dfrm_rx #(
  parameter int MAX_PAYLOAD = dfrm_pkg::MAX_PAYLOAD_DEF,
  parameter int ADDR_W      = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dfrm_pkg::cfg_regs_t   regs,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dfrm_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dfrm_pkg::out_item_t   out_data,
  output logic                  st_wr_en,
  output logic [ADDR_W-1:0]     st_wr_addr,
  output logic [7:0]            st_wr_data,
  output logic                  st_rd_en,
  output logic [ADDR_W-1:0]     st_rd_addr,
  input  logic [7:0]            st_rd_data
);

  // Counter widths: byte counts reach the length plus two CRC bytes.
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 3);
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  dfrm_pkg::phase_t    phase_r, phase_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    dec_r, dec_nxt;
  logic                pend_r, pend_nxt;
  logic [CNT_W-1:0]    esc_r, esc_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [15:0]         idle_r, idle_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [7:0]          prev_r, prev_nxt;
  logic [7:0]          total_r, total_nxt;
  dfrm_pkg::seq_t      seq_r, seq_nxt;
  logic [LEN_W-1:0]    emit_r, emit_nxt;
  logic                out_valid_r, out_valid_nxt;
  dfrm_pkg::out_item_t out_data_r, out_data_nxt;

  logic                out_free;
  logic                accept;
  logic                load_single;
  logic                load_good;
  logic                emit_last;
  dfrm_pkg::status_t   single_st;
  logic                clr;
  dfrm_pkg::phase_t    clr_phase;
  logic [7:0]          b;
  logic [7:0]          d;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (seq_r == dfrm_pkg::SEQ_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign b         = in_data.rx_byte;
  assign emit_last = (emit_r + LEN_W'(1)) == len_r;

  // Item decode and frame state update.
  always_comb begin
    phase_nxt   = phase_r;
    rem_nxt     = rem_r;
    dec_nxt     = dec_r;
    pend_nxt    = pend_r;
    esc_nxt     = esc_r;
    crc_nxt     = crc_r;
    idle_nxt    = idle_r;
    len_nxt     = len_r;
    prev_nxt    = prev_r;
    total_nxt   = total_r;
    seq_nxt     = seq_r;
    emit_nxt    = emit_r;
    load_single = 1'b0;
    load_good   = 1'b0;
    single_st   = dfrm_pkg::ST_NONE;
    clr         = 1'b0;
    clr_phase   = dfrm_pkg::PH_WAIT_START;
    d           = b;
    st_wr_en    = 1'b0;
    st_wr_addr  = dec_r[ADDR_W-1:0];
    st_wr_data  = b;
    st_rd_en    = 1'b0;
    st_rd_addr  = emit_r[ADDR_W-1:0];

    if (accept) begin
      load_single = 1'b1;
      if (in_data.command == dfrm_pkg::CMD_TICK) begin
        // Idle tick: count inside a frame, time out past the limit.
        if (phase_r != dfrm_pkg::PH_WAIT_START) begin
          if (regs.idle_limit != 16'h0000 && idle_r >= regs.idle_limit) begin
            clr       = 1'b1;
            single_st = dfrm_pkg::ST_TIMEOUT;
          end else if (idle_r != 16'hFFFF) begin
            idle_nxt = idle_r + 16'd1;
          end
        end
      end else begin
        idle_nxt = 16'h0000;
        if (phase_r != dfrm_pkg::PH_READ_ENC && b == regs.start_value) begin
          // Start byte outside the escaped region.
          clr       = 1'b1;
          clr_phase = dfrm_pkg::PH_WAIT_LEN;
          single_st = (phase_r == dfrm_pkg::PH_WAIT_START) ? dfrm_pkg::ST_TAKEN
                                                           : dfrm_pkg::ST_RESYNC;
        end else if (phase_r == dfrm_pkg::PH_WAIT_LEN) begin
          // Raw length byte.
          if (b == 8'h00 || b > 8'(MAX_PAYLOAD)) begin
            clr       = 1'b1;
            single_st = dfrm_pkg::ST_BADLEN;
          end else begin
            rem_nxt   = CNT_W'(b) + CNT_W'(2);
            len_nxt   = LEN_W'(b);
            phase_nxt = dfrm_pkg::PH_READ_ENC;
            single_st = dfrm_pkg::ST_TAKEN;
          end
        end else if (phase_r == dfrm_pkg::PH_READ_ENC) begin
          if (b == regs.escape_value && !pend_r) begin
            pend_nxt  = 1'b1;
            esc_nxt   = esc_r + CNT_W'(1);
            single_st = dfrm_pkg::ST_TAKEN;
          end else if (!pend_r && b == regs.start_value) begin
            clr       = 1'b1;
            clr_phase = dfrm_pkg::PH_WAIT_LEN;
            single_st = dfrm_pkg::ST_RESYNC;
          end else begin
            // Decoded byte: payload goes to the store, CRC bytes are held.
            if (pend_r) begin
              d = b ^ regs.escape_mask;
            end
            pend_nxt   = 1'b0;
            st_wr_data = d;
            if (rem_r > CNT_W'(2)) begin
              st_wr_en = 1'b1;
              crc_nxt  = dfrm_pkg::crc16_step(crc_r, d);
            end
            dec_nxt  = dec_r + CNT_W'(1);
            rem_nxt  = rem_r - CNT_W'(1);
            prev_nxt = d;
            if (rem_r == CNT_W'(1)) begin
              clr = 1'b1;
              if ({prev_r, d} != crc_r) begin
                single_st = dfrm_pkg::ST_BADCRC;
              end else begin
                // Good frame: hand over to the emission sequencer.
                load_single = 1'b0;
                total_nxt   = 8'd4 + 8'(len_r) + 8'(esc_r);
                emit_nxt    = '0;
                seq_nxt     = dfrm_pkg::SEQ_RD;
              end
            end else begin
              single_st = dfrm_pkg::ST_TAKEN;
            end
          end
        end
      end
    end

    // Frame clear shared by timeout, start, resync, error and frame-end paths.
    if (clr) begin
      phase_nxt = clr_phase;
      rem_nxt   = '0;
      dec_nxt   = '0;
      pend_nxt  = 1'b0;
      esc_nxt   = '0;
      crc_nxt   = 16'h0000;
      idle_nxt  = 16'h0000;
    end

    // Payload emission: read one entry, then move it to the output register.
    case (seq_r)
      dfrm_pkg::SEQ_IDLE: ;
      dfrm_pkg::SEQ_RD: begin
        st_rd_en = 1'b1;
        seq_nxt  = dfrm_pkg::SEQ_OUT;
      end
      dfrm_pkg::SEQ_OUT: begin
        if (out_free) begin
          load_good = 1'b1;
          if (emit_last) begin
            seq_nxt = dfrm_pkg::SEQ_IDLE;
          end else begin
            emit_nxt = emit_r + LEN_W'(1);
            seq_nxt  = dfrm_pkg::SEQ_RD;
          end
        end
      end
      default: seq_nxt = dfrm_pkg::SEQ_IDLE;
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_single) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.status       = single_st;
      out_data_nxt.payload_byte = 8'h00;
      out_data_nxt.frame_bytes  = 8'h00;
      out_data_nxt.last         = 1'b1;
    end else if (load_good) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.status       = dfrm_pkg::ST_GOOD;
      out_data_nxt.payload_byte = st_rd_data;
      out_data_nxt.frame_bytes  = total_r;
      out_data_nxt.last         = emit_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dfrm_pkg::PH_WAIT_START;
      rem_r       <= '0;
      dec_r       <= '0;
      pend_r      <= 1'b0;
      esc_r       <= '0;
      crc_r       <= 16'h0000;
      idle_r      <= 16'h0000;
      seq_r       <= dfrm_pkg::SEQ_IDLE;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      rem_r       <= rem_nxt;
      dec_r       <= dec_nxt;
      pend_r      <= pend_nxt;
      esc_r       <= esc_nxt;
      crc_r       <= crc_nxt;
      idle_r      <= idle_nxt;
      seq_r       <= seq_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    prev_r     <= prev_nxt;
    total_r    <= total_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DFRM_ASSERT(a_no_accept_while_emitting, seq_r != dfrm_pkg::SEQ_IDLE, !accept,
               "input accepted during payload emission")
  `DFRM_ASSERT(a_enc_has_bytes_left, phase_r == dfrm_pkg::PH_READ_ENC, rem_r != '0,
               "escaped region entered with no bytes left")
  `DFRM_ASSERT(a_pend_only_in_enc, pend_r, phase_r == dfrm_pkg::PH_READ_ENC,
               "escape pending outside the escaped region")
  `DFRM_ASSERT_NEXT(a_emit_ends_idle, seq_r == dfrm_pkg::SEQ_OUT && out_free && emit_last,
                    seq_r == dfrm_pkg::SEQ_IDLE && out_valid_r && out_data_r.last,
                    "final payload result not flagged last")

endmodule

/* rtl/core/escaped_frame_deframer_crc16_unit.sv */
// A byte or tick result is registered in the output register in the cycle after its transfer.
// Throughput: one byte or tick per cycle while results are taken and no payload is being
// emitted; the output register sets it. A good frame of L payload bytes gives L results, each
// a store read then an output load, and holds the input off until the last one is loaded.
// Reset (rst_n low, synchronous): registers to defaults, receiver waits for a start byte;
// the payload store is not cleared.
module escaped_frame_deframer_crc16_unit #(
  parameter int MAX_PAYLOAD = dfrm_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dfrm_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dfrm_pkg::out_item_t              out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [dfrm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [dfrm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [dfrm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  dfrm_pkg::cfg_regs_t regs;
  logic                st_wr_en;
  logic [ADDR_W-1:0]   st_wr_addr;
  logic [7:0]          st_wr_data;
  logic                st_rd_en;
  logic [ADDR_W-1:0]   st_rd_addr;
  logic [7:0]          st_rd_data;

  assign cfg_pready = 1'b1;

  // Configuration registers.
  dfrm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .regs        (regs)
  );

  // Payload store.
  dfrm_store #(
    .DEPTH  (MAX_PAYLOAD),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Decoder and emission sequencer.
  dfrm_rx #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .ADDR_W      (ADDR_W)
  ) u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .regs       (regs),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .st_wr_en   (st_wr_en),
    .st_wr_addr (st_wr_addr),
    .st_wr_data (st_wr_data),
    .st_rd_en   (st_rd_en),
    .st_rd_addr (st_rd_addr),
    .st_rd_data (st_rd_data)
  );

endmodule
